@@ rtl/tstc_pkg.sv @@
package tstc_pkg;

  // op codes carried in s_axis_tuser
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_CLOCK    = 3'd1;
  localparam logic [2:0] OP_INTERVAL = 3'd2;
  localparam logic [2:0] OP_DELTA    = 3'd3;
  localparam logic [2:0] OP_FLASH    = 3'd4;

  // configuration register indexes
  localparam logic CFG_SYNC_EXTERNAL = 1'b0;
  localparam logic CFG_TEMPO_PERCENT = 1'b1;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned TEMPO_W   = 10;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CREDIT_W  = 5;
  localparam int unsigned FLASH_W   = 9;
  localparam int unsigned FRAC_W    = 7;
  localparam int unsigned SCALED_W  = 26;
  localparam int unsigned IN_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [TEMPO_W-1:0]  TEMPO_RESET        = 10'd100;
  localparam logic [CREDIT_W-1:0] CLOCK_CREDIT_TICKS = 5'd20;
  localparam logic [FLASH_W-1:0]  FLASH_STEPS        = 9'd480;
  localparam int unsigned         SCALE_DIV          = 100;

  // x / 100 == (x * RECIP) >> 37 for every 32-bit x
  localparam logic [31:0] SCALE_RECIP = 32'h51EB_851F;
  localparam int unsigned SCALE_SHIFT = 37;

  // work handed from the event stage to the scaler
  typedef struct packed {
    logic                scale;
    logic [COUNT_W-1:0]  product;
    logic                flash;
  } scale_req_t;

endpackage

@@ rtl/tstc_front.sv @@
module tstc_front
  import tstc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [OP_W-1:0]     op_i,
  input  logic [DELTA_W-1:0]  delta_ticks_i,
  input  logic                sync_external_i,
  input  logic [TEMPO_W-1:0]  tempo_percent_i,
  output scale_req_t          req_o
);

  logic [COUNT_W-1:0]  elapsed_q, elapsed_d;
  logic [COUNT_W-1:0]  last_seen_q, last_seen_d;
  logic                primed_q, primed_d;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic [FLASH_W-1:0]  flash_cnt_q, flash_cnt_d;
  scale_req_t          req_q, req_d;

  logic [COUNT_W-1:0]         diff;
  logic [COUNT_W-1:0]         mult_a;
  logic [COUNT_W+TEMPO_W-1:0] mult_full;

  assign diff      = elapsed_q - last_seen_q;
  assign mult_a    = (op_i == OP_DELTA) ? {{(COUNT_W-DELTA_W){1'b0}}, delta_ticks_i} : diff;
  assign mult_full = mult_a * tempo_percent_i;

  always_comb begin
    elapsed_d     = elapsed_q;
    last_seen_d   = last_seen_q;
    primed_d      = primed_q;
    credit_d      = credit_q;
    flash_cnt_d   = flash_cnt_q;
    req_d.scale   = 1'b0;
    req_d.product = mult_full[COUNT_W-1:0];
    req_d.flash   = 1'b0;
    case (op_i)
      OP_TICK: begin
        if (!sync_external_i) begin
          elapsed_d = elapsed_q + 32'd1;
        end else if (credit_q != '0) begin
          elapsed_d = elapsed_q + 32'd1;
          credit_d  = credit_q - 5'd1;
        end
      end
      OP_CLOCK: begin
        // leftover credit is flushed into the counter at once
        if (sync_external_i) begin
          elapsed_d = elapsed_q + COUNT_W'(credit_q);
          credit_d  = CLOCK_CREDIT_TICKS;
        end
      end
      OP_INTERVAL: begin
        last_seen_d = elapsed_q;
        primed_d    = 1'b1;
        req_d.scale = primed_q;
      end
      OP_DELTA: begin
        req_d.scale = 1'b1;
      end
      OP_FLASH: begin
        if (flash_cnt_q <= 9'd1) begin
          flash_cnt_d = FLASH_STEPS;
          req_d.flash = 1'b1;
        end else begin
          flash_cnt_d = flash_cnt_q - 9'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      last_seen_q <= '0;
      primed_q    <= 1'b0;
      credit_q    <= '0;
      flash_cnt_q <= '0;
    end else if (accept_i) begin
      elapsed_q   <= elapsed_d;
      last_seen_q <= last_seen_d;
      primed_q    <= primed_d;
      credit_q    <= credit_d;
      flash_cnt_q <= flash_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

@@ rtl/tstc_scaler.sv @@
module tstc_scaler
  import tstc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_div_i,
  input  logic                load_out_i,
  input  scale_req_t          req_i,
  output logic [SCALED_W-1:0] scaled_count_o,
  output logic                led_flash_o
);

  localparam logic [FRAC_W-1:0] DIV_LOW = FRAC_W'(SCALE_DIV);
  localparam logic [FRAC_W:0]   DIV_CMP = (FRAC_W+1)'(SCALE_DIV);

  // divide stage
  logic [2*COUNT_W-1:0] recip_full;
  scale_req_t           req_q;
  logic [SCALED_W-1:0]  quot_q;

  assign recip_full = {{COUNT_W{1'b0}}, req_i.product} * SCALE_RECIP;

  always_ff @(posedge clk_i) begin
    if (load_div_i) begin
      req_q  <= req_i;
      quot_q <= recip_full[SCALE_SHIFT +: SCALED_W];
    end
  end

  // remainder and fraction carry
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic [FRAC_W-1:0]  quot_x100;
  logic [FRAC_W-1:0]  rem;
  logic [FRAC_W:0]    frac_sum;
  logic [COUNT_W:0]   acc_full;
  logic [SCALED_W-1:0] count_d;
  logic [SCALED_W-1:0] count_q;
  logic                flash_q;

  assign quot_x100 = quot_q[FRAC_W-1:0] * DIV_LOW;
  assign rem       = req_q.product[FRAC_W-1:0] - quot_x100;
  assign frac_sum  = {1'b0, rem} + {1'b0, frac_q};
  assign acc_full  = {1'b0, req_q.product} + (COUNT_W+1)'(frac_q);

  always_comb begin
    frac_d  = frac_q;
    count_d = '0;
    if (req_q.scale) begin
      if (acc_full[COUNT_W]) begin
        // sum wrapped past 32 bits: what is left is below one clock
        frac_d = acc_full[FRAC_W-1:0];
      end else if (frac_sum >= DIV_CMP) begin
        count_d = quot_q + 26'd1;
        frac_d  = FRAC_W'(frac_sum - DIV_CMP);
      end else begin
        count_d = quot_q;
        frac_d  = frac_sum[FRAC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= '0;
    end else if (load_out_i) begin
      frac_q <= frac_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_i) begin
      count_q <= count_d;
      flash_q <= req_q.flash;
    end
  end

  assign scaled_count_o = count_q;
  assign led_flash_o    = flash_q;

endmodule

@@ rtl/tempo_scaled_tick_clock.sv @@
// Tempo-scaled tick clock.
// Input words arrive on s_axis: tuser carries the op (tick, external clock,
// interval query, delta query, flash query), tdata carries delta_ticks.
// Every input word yields exactly one output word on m_axis, in order:
// scaled_count (whole scaled clocks for the two queries, else zero) and
// led_flash. Registers are written through cfg_we_i / cfg_index_i /
// cfg_data_i; the user must write them only while no word is in flight,
// since the block does not enforce this. It has three register stages:
// the event stage (counter update and the 32x10 tempo multiply), the
// reciprocal divide by 100, and the fraction carry into the output register.
// Throughput is one word per cycle while the receiver does not stall; the
// fraction carry closes its loop within the last stage, which allows this.
// Reset clears the counters, credit, flash countdown and fraction, sets
// tempo to 100 percent and internal pacing, and empties the pipeline.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// s_axis_tready drops only once all three stages hold words.
module tempo_scaled_tick_clock
  import tstc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] delta_ticks
  input  logic [OP_W-1:0]       s_axis_tuser,   // [2:0] op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [25:0] scaled_count, [26] led_flash
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic               sync_q;
  logic [TEMPO_W-1:0] tempo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q  <= 1'b0;
      tempo_q <= TEMPO_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SYNC_EXTERNAL: sync_q  <= cfg_data_i[0];
        CFG_TEMPO_PERCENT: tempo_q <= cfg_data_i[TEMPO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage occupancy
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic accept;

  assign rdy3   = !v3_q || m_axis_tready;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign accept = s_axis_tvalid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept || (v1_q && !rdy2);
      v2_q <= (v1_q && rdy2) || (v2_q && !rdy3);
      v3_q <= (v2_q && rdy3) || (v3_q && !m_axis_tready);
    end
  end

  scale_req_t          req;
  logic [SCALED_W-1:0] scaled_count;
  logic                led_flash;

  tstc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .op_i            (s_axis_tuser),
    .delta_ticks_i   (s_axis_tdata[DELTA_W-1:0]),
    .sync_external_i (sync_q),
    .tempo_percent_i (tempo_q),
    .req_o           (req)
  );

  tstc_scaler u_scaler (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_div_i     (v1_q && rdy2),
    .load_out_i     (v2_q && rdy3),
    .req_i          (req),
    .scaled_count_o (scaled_count),
    .led_flash_o    (led_flash)
  );

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-SCALED_W-1){1'b0}}, led_flash, scaled_count};

endmodule

@@ rtl/tstc_checker.sv @@
module tstc_checker
  import tstc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled output word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // a stalled output word keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // input backpressure only when the pipeline is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

  // a fresh output word traces back to an accepted input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
    else $error("output word without a matching input word");

endmodule

bind tempo_scaled_tick_clock tstc_checker u_tstc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ test/tempo_clock_checker.sv @@
module tempo_clock_checker
  import tstc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] delta_ticks
  input  logic [OP_W-1:0]       s_axis_tuser,   // [2:0] op
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [25:0] scaled_count, [26] led_flash
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [SCALED_W-1:0] scaled;
    logic                flash;
  } clock_word_t;

  clock_word_t expected_words[$];
  clock_word_t want;

  // shadow copy of the block's registers and counters
  logic                sync_ext;
  logic [TEMPO_W-1:0]  tempo;
  logic [COUNT_W-1:0]  elapsed;
  logic [COUNT_W-1:0]  last_seen;
  logic                primed;
  logic [FRAC_W-1:0]   frac;
  logic [CREDIT_W-1:0] credit;
  logic [FLASH_W-1:0]  flash_cd;

  int mismatches = 0;

  assign fail_count_o = mismatches;

  // remainder below 100 carries over to the next scaling
  function automatic logic [SCALED_W-1:0] scale_by_tempo(input logic [COUNT_W-1:0] product);
    logic [COUNT_W-1:0] acc;
    acc = product + COUNT_W'(frac);
    frac = FRAC_W'(acc % SCALE_DIV);
    return SCALED_W'(acc / SCALE_DIV);
  endfunction

  function automatic clock_word_t advance_clock(input logic [OP_W-1:0] op,
                                                input logic [DELTA_W-1:0] delta);
    clock_word_t w;
    logic [COUNT_W-1:0] diff;
    w = '0;
    case (op)
      OP_TICK: begin
        if (!sync_ext) begin
          elapsed = elapsed + COUNT_W'(1);
        end else if (credit != '0) begin
          elapsed = elapsed + COUNT_W'(1);
          credit = credit - CREDIT_W'(1);
        end
      end
      OP_CLOCK: begin
        // leftover credit is booked at once
        if (sync_ext) begin
          elapsed = elapsed + COUNT_W'(credit);
          credit = CLOCK_CREDIT_TICKS;
        end
      end
      OP_INTERVAL: begin
        if (!primed) begin
          last_seen = elapsed;
          primed = 1'b1;
        end else begin
          diff = elapsed - last_seen;
          last_seen = elapsed;
          w.scaled = scale_by_tempo(diff * COUNT_W'(tempo));
        end
      end
      OP_DELTA: begin
        w.scaled = scale_by_tempo(COUNT_W'(delta) * COUNT_W'(tempo));
      end
      OP_FLASH: begin
        if (flash_cd <= FLASH_W'(1)) begin
          flash_cd = FLASH_STEPS;
          w.flash = 1'b1;
        end else begin
          flash_cd = flash_cd - FLASH_W'(1);
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_ext = 1'b0;
      tempo = TEMPO_RESET;
      elapsed = '0;
      last_seen = '0;
      primed = 1'b0;
      frac = '0;
      credit = '0;
      flash_cd = '0;
      expected_words.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: word %h arrived with nothing expected", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[SCALED_W-1:0] !== want.scaled) begin
            $display("%0t: scaled_count expected %0d got %0d", $time, want.scaled,
                     m_axis_tdata[SCALED_W-1:0]);
            mismatches++;
          end
          if (m_axis_tdata[SCALED_W] !== want.flash) begin
            $display("%0t: led_flash expected %0b got %0b", $time, want.flash,
                     m_axis_tdata[SCALED_W]);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SYNC_EXTERNAL) sync_ext = cfg_data_i[0];
        else tempo = cfg_data_i[TEMPO_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(advance_clock(s_axis_tuser, s_axis_tdata[DELTA_W-1:0]));
      end
      pending_o = expected_words.size();
    end
  end

endmodule

@@ test/tempo_scaled_tick_clock_tb.sv @@
module tempo_scaled_tick_clock_tb;
  import tstc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // op codes the block leaves alone
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending_words;
  int cycle_count = 0;

  bit quiet_mode   = 1'b0;
  bit hold_request = 1'b0;
  int no_gap_left  = 0;

  tempo_scaled_tick_clock uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  tempo_clock_checker clock_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_word(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] delta);
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'(delta);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_and_configure(input logic sync_val, input logic [TEMPO_W-1:0] tempo_val);
    s_axis_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SYNC_EXTERNAL;
    cfg_data_i  <= CFG_DATA_W'(sync_val);
    @(negedge clk_i);
    cfg_index_i <= CFG_TEMPO_PERCENT;
    cfg_data_i  <= tempo_val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [OP_W-1:0] pick_op(input int clock_pct, input bit flash_heavy);
    int r;
    if (flash_heavy) return OP_FLASH;
    if ($urandom_range(0, 99) < clock_pct) return OP_CLOCK;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_TICK;
    if (r < 62) return OP_INTERVAL;
    if (r < 79) return OP_DELTA;
    if (r < 92) return OP_FLASH;
    case ($urandom_range(0, 2))
      0:       return OP_SPARE_A;
      1:       return OP_SPARE_B;
      default: return OP_SPARE_C;
    endcase
  endfunction

  function automatic logic [DELTA_W-1:0] pick_delta();
    case ($urandom_range(0, 3))
      0:       return DELTA_W'($urandom_range(0, 99));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return DELTA_W'($urandom);
    endcase
  endfunction

  initial begin : receiver
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 64;
        run_left = 0;
      end else if (stall_left == 0 && run_left == 0) begin
        if (!quiet_mode && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 19);
        else run_left = $urandom_range(1, 30);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  initial begin : stimulus
    int clock_pct;
    int word_count;
    bit flash_heavy;
    logic sync_val;
    logic [TEMPO_W-1:0] tempo_val;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_SYNC_EXTERNAL;
    cfg_data_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: internal pacing, tempo 100
    offer_word(OP_FLASH, '0);         // countdown at zero reloads and flashes
    offer_word(OP_FLASH, '0);
    offer_word(OP_DELTA, '1);
    offer_word(OP_DELTA, '0);
    offer_word(OP_INTERVAL, '0);      // first query only primes
    offer_word(OP_TICK, '1);
    offer_word(OP_TICK, '0);
    offer_word(OP_TICK, 16'h5555);
    offer_word(OP_CLOCK, '0);         // ignored while counting every tick
    offer_word(OP_INTERVAL, 16'hAAAA);
    offer_word(OP_SPARE_A, '1);
    offer_word(OP_SPARE_B, '1);
    offer_word(OP_SPARE_C, '1);

    drain_and_configure(1'b1, 10'd1023);
    offer_word(OP_TICK, '0);          // no credit yet
    offer_word(OP_CLOCK, '0);
    offer_word(OP_TICK, '0);
    offer_word(OP_TICK, '0);
    offer_word(OP_CLOCK, '0);         // books the 18 left over
    offer_word(OP_INTERVAL, '0);
    offer_word(OP_DELTA, '1);
    offer_word(OP_DELTA, 16'h5555);
    offer_word(OP_DELTA, 16'hAAAA);

    for (int ph = 0; ph < 6; ph++) begin
      flash_heavy = 1'b0;
      clock_pct = 10;
      word_count = 12;
      case (ph)
        0: begin
          sync_val = 1'b0;
          tempo_val = TEMPO_W'($urandom_range(1, 999));
        end
        1: begin
          sync_val = 1'b1;
          tempo_val = 10'd1000;
          clock_pct = 25;
        end
        2: begin
          // scarce clocks so ticks run out of credit
          sync_val = 1'b1;
          tempo_val = TEMPO_W'($urandom_range(1, 99));
          clock_pct = 3;
        end
        3: begin
          sync_val = 1'b0;
          tempo_val = '0;
        end
        4: begin
          // long enough to walk the led countdown down to its end
          sync_val = 1'($urandom_range(0, 1));
          tempo_val = TEMPO_W'($urandom_range(0, 1023));
          flash_heavy = 1'b1;
          word_count = 480;
        end
        default: begin
          sync_val = 1'b1;
          tempo_val = 10'd1023;
          clock_pct = 15;
          quiet_mode = 1'b1;
        end
      endcase
      drain_and_configure(sync_val, tempo_val);
      if (ph == 1) begin
        // receiver holds off while words keep coming, so the pipe backs up
        hold_request = 1'b1;
        no_gap_left = 30;
      end
      repeat (word_count) offer_word(pick_op(clock_pct, flash_heavy), pick_delta());
    end

    s_axis_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
